>>> hdl/csfb_pkg.sv
// ----------------------------------------------------------------------------
// csfb_pkg
// Shared types, constants and tables of the complex band-pass filter.
// ----------------------------------------------------------------------------
package csfb_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int PHASE_W    = 24;
  localparam int KIND_W     = 2;
  localparam int TAP_IDX_W  = 7;
  localparam int TAP_CNT_W  = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // trig and cordic
  localparam int TRIG_FRAC     = 15;
  localparam int CORDIC_STAGES = 16;
  localparam int CRD_STEP_W    = $clog2(CORDIC_STAGES);
  localparam int CRD_X_W       = 33;
  localparam int CRD_Z_W       = PHASE_W + 1;
  localparam int CORDIC_X0     = 652032874;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 4'd1;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 8'd128;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    sample_t re;
    sample_t im;
  } cplx_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    sample_t cos_v;
    sample_t sin_v;
  } trig_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MD_I,
    ST_MD_Q,
    ST_MD_END,
    ST_SHIFT,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_MU_I,
    ST_MU_Q,
    ST_MU_END,
    ST_OUT
  } fir_state_e;

  typedef enum logic [1:0] {
    CRD_IDLE,
    CRD_ITER,
    CRD_ROUND
  } crd_state_e;

  // arctangent of 2^-i in units of 2^-24 turn
  function automatic logic signed [CRD_Z_W-1:0] cordic_arc(input logic [CRD_STEP_W-1:0] idx);
    logic signed [CRD_Z_W-1:0] arc;
    unique case (idx)
      4'd0:    arc = 25'sd2097152;
      4'd1:    arc = 25'sd1238021;
      4'd2:    arc = 25'sd654136;
      4'd3:    arc = 25'sd332050;
      4'd4:    arc = 25'sd166669;
      4'd5:    arc = 25'sd83416;
      4'd6:    arc = 25'sd41718;
      4'd7:    arc = 25'sd20860;
      4'd8:    arc = 25'sd10430;
      4'd9:    arc = 25'sd5215;
      4'd10:   arc = 25'sd2608;
      4'd11:   arc = 25'sd1304;
      4'd12:   arc = 25'sd652;
      4'd13:   arc = 25'sd326;
      4'd14:   arc = 25'sd163;
      default: arc = 25'sd81;
    endcase
    return arc;
  endfunction

endpackage

>>> hdl/csfb_if.sv
// ----------------------------------------------------------------------------
// csfb channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface csfb_in_if import csfb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [KIND_W-1:0]           kind;
  sample_t                     sample_i;
  sample_t                     sample_q;
  logic [TAP_IDX_W-1:0]        tap_index;
  logic signed [COEF_W-1:0]    coef_value;

  modport source (output valid, kind, sample_i, sample_q, tap_index, coef_value, input ready);
  modport sink   (input valid, kind, sample_i, sample_q, tap_index, coef_value, output ready);
endinterface

interface csfb_out_if import csfb_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_i;
  sample_t out_q;
  logic    saturated;

  modport source (output valid, out_i, out_q, saturated, input ready);
  modport sink   (input valid, out_i, out_q, saturated, output ready);
endinterface

interface csfb_cfg_if import csfb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/csfb_cell.sv
// ----------------------------------------------------------------------------
// csfb_cell
// One delay-line cell: holds a mixed complex sample, takes its neighbour's.
// ----------------------------------------------------------------------------
module csfb_cell import csfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cplx_t      d_i,
  output cplx_t      q_o
);

  cplx_t val_q;

  // clear wins over shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (ctrl_i.clr) begin
      val_q <= '0;
    end else if (ctrl_i.shift) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

>>> hdl/csfb_cordic.sv
// ----------------------------------------------------------------------------
// csfb_cordic
// Iterative CORDIC, one micro-rotation a cycle, giving Q1.15 cos and sin.
// ----------------------------------------------------------------------------
module csfb_cordic import csfb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [PHASE_W-1:0] phase_i,
  output logic               done_o,
  output trig_t              trig_o
);

  localparam logic signed [CRD_Z_W-1:0] Q_TURN    = CRD_Z_W'(1 << (PHASE_W-2));
  localparam logic signed [CRD_Z_W-1:0] HALF_TURN = CRD_Z_W'(1 << (PHASE_W-1));
  localparam logic signed [CRD_X_W-1:0] X_HALF    = CRD_X_W'(1 << (TRIG_FRAC-1));
  localparam logic signed [CRD_X_W-1:0] TRIG_LIM  = CRD_X_W'((1 << TRIG_FRAC) - 1);
  localparam logic [CRD_STEP_W-1:0]     LAST_STEP = CRD_STEP_W'(CORDIC_STAGES-1);

  crd_state_e                 state_q, state_d;
  logic signed [CRD_X_W-1:0]  x_q, y_q, dx, dy, x_rnd, y_rnd;
  logic signed [CRD_Z_W-1:0]  z_q, z_raw, z_fold, arc;
  logic                       flip_q, flip_d;
  logic [CRD_STEP_W-1:0]      step_q;
  logic                       done_q;
  trig_t                      trig_q;

  // clamp the half-up rounded value to +-32767, then undo the half-turn fold
  function automatic sample_t trig_clamp(input logic signed [CRD_X_W-1:0] v, input logic neg);
    logic signed [CRD_X_W-1:0] lim_v;
    sample_t                   r16;
    if (v > TRIG_LIM) begin
      lim_v = TRIG_LIM;
    end else if (v < -TRIG_LIM) begin
      lim_v = -TRIG_LIM;
    end else begin
      lim_v = v;
    end
    r16 = SAMPLE_W'(lim_v);
    return neg ? -r16 : r16;
  endfunction

  // fold phase into +-quarter turn
  always_comb begin
    z_raw  = CRD_Z_W'(signed'(phase_i));
    z_fold = z_raw;
    flip_d = 1'b0;
    if (z_raw > Q_TURN) begin
      z_fold = z_raw - HALF_TURN;
      flip_d = 1'b1;
    end else if (z_raw < -Q_TURN) begin
      z_fold = z_raw + HALF_TURN;
      flip_d = 1'b1;
    end
  end

  // micro-rotation operands
  assign dx    = y_q >>> step_q;
  assign dy    = x_q >>> step_q;
  assign arc   = cordic_arc(step_q);
  assign x_rnd = (x_q + X_HALF) >>> TRIG_FRAC;
  assign y_rnd = (y_q + X_HALF) >>> TRIG_FRAC;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CRD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == CRD_ROUND);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CRD_IDLE:  if (start_i) state_d = CRD_ITER;
      CRD_ITER:  if (step_q == LAST_STEP) state_d = CRD_ROUND;
      CRD_ROUND: state_d = CRD_IDLE;
      default:   state_d = CRD_IDLE;
    endcase
  end

  // rotation datapath
  always_ff @(posedge clk_i) begin
    if (state_q == CRD_IDLE && start_i) begin
      x_q    <= CRD_X_W'(CORDIC_X0);
      y_q    <= '0;
      z_q    <= z_fold;
      flip_q <= flip_d;
      step_q <= '0;
    end else if (state_q == CRD_ITER) begin
      step_q <= step_q + 1'b1;
      if (!z_q[CRD_Z_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - arc;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + arc;
      end
    end
    if (state_q == CRD_ROUND) begin
      trig_q.cos_v <= trig_clamp(x_rnd, flip_q);
      trig_q.sin_v <= trig_clamp(y_rnd, flip_q);
    end
  end

  assign done_o = done_q;
  assign trig_o = trig_q;

endmodule

>>> hdl/complex_shift_fir_bandpass.sv
// ----------------------------------------------------------------------------
// complex_shift_fir_bandpass
// Complex band-pass: mix down by the phase, real FIR over a ring of delay
// cells, mix back up. Coefficients arrive as load items.
// ----------------------------------------------------------------------------
//  channel  dir  modport      carries
//  cfg_i    in   cfg sink     register index, write data
//  in_i     in   in sink      kind, sample_i/q, tap_index, coef_value
//  out_o    out  out source   out_i/q, saturated (one per sample item)
//
//  A sample item runs the CORDIC, one pass of the cell ring past the single
//  complex MAC, and the mixers and pipeline around it. Load and clear items
//  are taken in the idle state and do not leave it.
//  Reset clears the cells, phase, coefficient valid bits and registers at
//  once; no clearing pass. A held result stalls only the finishing sample,
//  the next item is taken while the result waits in the output register.
// ----------------------------------------------------------------------------
module complex_shift_fir_bandpass import csfb_pkg::*; #(
  parameter int MAX_TAPS = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csfb_cfg_if.sink   cfg_i,
  csfb_in_if.sink    in_i,
  csfb_out_if.source out_o
);

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int NW     = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + AW;
  localparam int Y_W    = ACC_W - COEF_W + 2;
  localparam int MIX_W  = Y_W + SAMPLE_W;
  localparam int SUM_W  = MIX_W + 1;

  localparam logic [AW-1:0]            LAST_TAP  = AW'(MAX_TAPS - 1);
  localparam logic [AW-1:0]            DRAIN_END = AW'(1);
  localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1 << (COEF_W-2));
  localparam logic signed [SUM_W-1:0]  MIX_HALF  = SUM_W'(1 << (TRIG_FRAC-1));
  localparam logic signed [SUM_W-1:0]  SAT_HI    = SUM_W'((1 << (SAMPLE_W-1)) - 1);
  localparam logic signed [SUM_W-1:0]  SAT_LO    = SUM_W'(-(1 << (SAMPLE_W-1)));

  fir_state_e state_q, state_d;

  // configuration registers
  logic [PHASE_W-1:0]   phase_step_q;
  logic [TAP_CNT_W-1:0] tap_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      tap_count_q  <= TAP_COUNT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_PHASE_STEP) begin
        phase_step_q <= cfg_i.data[PHASE_W-1:0];
      end else if (cfg_i.index == CFG_TAP_COUNT) begin
        tap_count_q <= cfg_i.data[TAP_CNT_W-1:0];
      end
    end
  end

  // input transfer decode
  logic in_fire, take_sample, take_load, take_clear;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign take_sample = in_fire && (in_i.kind == KIND_SAMPLE);
  assign take_clear  = in_fire && (in_i.kind == KIND_CLEAR);
  assign take_load   = in_fire && (in_i.kind == KIND_LOAD) &&
                       (32'(in_i.tap_index) < MAX_TAPS);

  // phase accumulator and sample latch
  logic [PHASE_W-1:0] phase_q, phase_next;
  cplx_t              x_q;

  assign phase_next = phase_q + phase_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (take_clear) begin
      phase_q <= '0;
    end else if (take_sample) begin
      phase_q <= phase_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_sample) begin
      x_q.re <= in_i.sample_i;
      x_q.im <= in_i.sample_q;
    end
  end

  // cos/sin of the new phase
  logic  trig_done;
  trig_t trig;

  csfb_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (take_sample),
    .phase_i (phase_next),
    .done_o  (trig_done),
    .trig_o  (trig)
  );

  // tap counter
  logic [AW-1:0] cnt_q, cnt_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  logic out_valid_q, out_load;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // next state and tap count
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      ST_IDLE:   if (take_sample) state_d = ST_TRIG;
      ST_TRIG:   if (trig_done) state_d = ST_MD_I;
      ST_MD_I:   state_d = ST_MD_Q;
      ST_MD_Q:   state_d = ST_MD_END;
      ST_MD_END: state_d = ST_SHIFT;
      ST_SHIFT:  state_d = ST_RUN;
      ST_RUN: begin
        if (cnt_q == LAST_TAP) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt_q == DRAIN_END) begin
          state_d = ST_ROUND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ROUND:  state_d = ST_MU_I;
      ST_MU_I:   state_d = ST_MU_Q;
      ST_MU_Q:   state_d = ST_MU_END;
      ST_MU_END: state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ring of delay cells; cell k holds the sample of delay k after the shift
  cplx_t      hist [MAX_TAPS];
  cplx_t      mixed_q, head_d;
  cell_ctrl_t cell_ctrl;

  assign head_d          = (state_q == ST_SHIFT) ? mixed_q : hist[MAX_TAPS-1];
  assign cell_ctrl.clr   = take_clear;
  assign cell_ctrl.shift = (state_q == ST_SHIFT) || (state_q == ST_RUN);

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      csfb_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .d_i    (head_d),
        .q_o    (hist[k])
      );
    end else begin : g_body
      csfb_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .d_i    (hist[k-1]),
        .q_o    (hist[k])
      );
    end
  end

  // taps in use and the first ring step that meets a live tap
  logic [NW-1:0] tap_n;
  logic [AW-1:0] first_tap, coef_addr;
  logic          tap_use;

  always_comb begin
    if (tap_count_q == '0) begin
      tap_n = NW'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      tap_n = NW'(MAX_TAPS);
    end else begin
      tap_n = NW'(tap_count_q);
    end
  end

  assign first_tap = AW'(MAX_TAPS - 32'(tap_n));
  assign tap_use   = (state_q == ST_RUN) && (cnt_q >= first_tap);
  assign coef_addr = cnt_q - first_tap;

  // coefficient memory with valid bits, registered read
  logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]      coef_vld_q;
  logic signed [COEF_W-1:0] coef_rd_q;
  cplx_t                    tail_q;

  always_ff @(posedge clk_i) begin
    if (take_load) begin
      coef_mem[AW'(in_i.tap_index)] <= in_i.coef_value;
    end
    coef_rd_q <= coef_mem[coef_addr];
    tail_q    <= hist[MAX_TAPS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (take_load) begin
      coef_vld_q[AW'(in_i.tap_index)] <= 1'b1;
    end
  end

  // MAC pipeline: operand stage, product stage, accumulate
  logic                     use_q, coef_ok_q;
  logic signed [PROD_W-1:0] prod_i_q, prod_q_q;
  logic signed [ACC_W-1:0]  acc_i_q, acc_q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q     <= 1'b0;
      coef_ok_q <= 1'b0;
    end else begin
      use_q     <= tap_use;
      coef_ok_q <= coef_vld_q[coef_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (use_q && coef_ok_q) begin
      prod_i_q <= coef_rd_q * tail_q.re;
      prod_q_q <= coef_rd_q * tail_q.im;
    end else begin
      prod_i_q <= '0;
      prod_q_q <= '0;
    end
    if (state_q == ST_SHIFT) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else begin
      acc_i_q <= acc_i_q + ACC_W'(prod_i_q);
      acc_q_q <= acc_q_q + ACC_W'(prod_q_q);
    end
  end

  // filter output rounded to 15 fraction bits (Q10.15 at MAX_TAPS 128), no saturation
  logic signed [ACC_W-1:0] acc_rnd_i, acc_rnd_q;
  logic signed [Y_W-1:0]   y_i_q, y_q_q;

  assign acc_rnd_i = acc_i_q + ACC_HALF;
  assign acc_rnd_q = acc_q_q + ACC_HALF;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROUND) begin
      y_i_q <= Y_W'(acc_rnd_i >>> (COEF_W-1));
      y_q_q <= Y_W'(acc_rnd_q >>> (COEF_W-1));
    end
  end

  // shared mixer: two products a cycle, then add or subtract, round, clip
  logic signed [Y_W-1:0]   mul_a1, mul_a2;
  sample_t                 mul_b1, mul_b2;
  logic                    sub_d, sub_q;
  logic signed [MIX_W-1:0] pa_q, pb_q;
  logic signed [SUM_W-1:0] mix_sum, mix_rnd;
  sample_t                 mix_res;
  logic                    mix_clip;

  always_comb begin
    mul_a1 = '0;
    mul_b1 = '0;
    mul_a2 = '0;
    mul_b2 = '0;
    sub_d  = 1'b0;
    unique case (state_q)
      ST_MD_I: begin
        mul_a1 = Y_W'(x_q.re);
        mul_b1 = trig.cos_v;
        mul_a2 = Y_W'(x_q.im);
        mul_b2 = trig.sin_v;
      end
      ST_MD_Q: begin
        mul_a1 = Y_W'(x_q.im);
        mul_b1 = trig.cos_v;
        mul_a2 = Y_W'(x_q.re);
        mul_b2 = trig.sin_v;
        sub_d  = 1'b1;
      end
      ST_MU_I: begin
        mul_a1 = y_i_q;
        mul_b1 = trig.cos_v;
        mul_a2 = y_q_q;
        mul_b2 = trig.sin_v;
        sub_d  = 1'b1;
      end
      ST_MU_Q: begin
        mul_a1 = y_i_q;
        mul_b1 = trig.sin_v;
        mul_a2 = y_q_q;
        mul_b2 = trig.cos_v;
      end
      default: begin
        sub_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pa_q  <= mul_a1 * mul_b1;
    pb_q  <= mul_a2 * mul_b2;
    sub_q <= sub_d;
  end

  always_comb begin
    mix_sum  = sub_q ? (SUM_W'(pa_q) - SUM_W'(pb_q)) : (SUM_W'(pa_q) + SUM_W'(pb_q));
    mix_rnd  = (mix_sum + MIX_HALF) >>> TRIG_FRAC;
    mix_clip = 1'b0;
    if (mix_rnd > SAT_HI) begin
      mix_res  = SAMPLE_MAX;
      mix_clip = 1'b1;
    end else if (mix_rnd < SAT_LO) begin
      mix_res  = SAMPLE_MIN;
      mix_clip = 1'b1;
    end else begin
      mix_res = SAMPLE_W'(mix_rnd);
    end
  end

  // mixer results
  cplx_t res_q;
  logic  clip_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MD_Q:   mixed_q.re <= mix_res;
      ST_MD_END: mixed_q.im <= mix_res;
      ST_MU_Q: begin
        res_q.re <= mix_res;
        clip_q   <= mix_clip;
      end
      ST_MU_END: begin
        res_q.im <= mix_res;
        clip_q   <= clip_q | mix_clip;
      end
      default: begin
        clip_q <= clip_q;
      end
    endcase
  end

  // output register
  cplx_t res_out_q;
  logic  sat_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_out_q <= res_q;
      sat_out_q <= clip_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_i     = res_out_q.re;
  assign out_o.out_q     = res_out_q.im;
  assign out_o.saturated = sat_out_q;

  // checks
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT |=> state_q == ST_RUN && cnt_q == '0 && acc_i_q == '0 && acc_q_q == '0)
    else $error("ring pass did not start clean");

  a_trig_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_done |-> state_q == ST_TRIG)
    else $error("cordic finished while sequencer not waiting");

  a_tap_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    use_q |-> $past(state_q) == ST_RUN)
    else $error("tap used outside the ring pass");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_o.ready) |=> state_q == ST_OUT)
    else $error("result left before output register was free");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == LAST_TAP) |=> state_q == ST_DRAIN)
    else $error("ring pass length wrong");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex band-pass filter. A bit-true model of
// the phase CORDIC, the down-mixer, the real FIR and the up-mixer predicts
// each filtered sample at input transfer time; a monitor compares every
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import csfb_pkg::*;

  localparam int TAPS           = 128;
  localparam int SETTLE         = TAPS + 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET    = 1100;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [TAP_IDX_W-1:0]     tap_idx_t;
  typedef logic [PHASE_W-1:0]       phase_t;
  typedef logic [TAP_CNT_W-1:0]     tcount_t;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct {
    logic [KIND_W-1:0] kind;
    sample_t           re;
    sample_t           im;
    tap_idx_t          tap;
    coef_t             coef;
  } item_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
    logic    sat;
  } filt_res_t;

  logic clk;
  logic rst_n;
  bit   idle_on;

  csfb_cfg_if cfg_if ();
  csfb_in_if  in_if ();
  csfb_out_if out_if ();

  complex_shift_fir_bandpass #(
    .MAX_TAPS(TAPS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state
  phase_t    cfg_step;
  tcount_t   cfg_taps;
  phase_t    phase_acc;
  longint    coef_mem [TAPS];
  longint    hist_re [TAPS-1];
  longint    hist_im [TAPS-1];
  longint    arc_turns [CORDIC_STAGES];
  filt_res_t filtered_q [$];

  // run statistics
  int n_items;
  int n_samples;
  int n_loads;
  int n_clears;
  int n_ignored;
  int n_cfg;
  int n_checked;
  int n_clipped;
  int n_errors;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // bit-true predictor
  // ------------------------------------------------------------------------

  function automatic longint rnd_shift(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip_q15(input longint v, inout bit hit);
    if (v > longint'(SAMPLE_MAX)) begin
      hit = 1'b1;
      return longint'(SAMPLE_MAX);
    end
    if (v < longint'(SAMPLE_MIN)) begin
      hit = 1'b1;
      return longint'(SAMPLE_MIN);
    end
    return v;
  endfunction

  // cos and sin of a phase, folded about the half turn, cordic in Q2.30
  function automatic void phase_trig(input phase_t ph, output longint cv, output longint sv);
    longint z, x, y, dx, dy;
    bit     flip;
    int     i;
    flip = 1'b0;
    z    = longint'(ph);
    if (z >= 8388608) z -= 16777216;
    if (z > 4194304) begin
      z -= 8388608;
      flip = 1'b1;
    end else if (z < -4194304) begin
      z += 8388608;
      flip = 1'b1;
    end
    x = CORDIC_X0;
    y = 0;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arc_turns[i];
      end else begin
        x += dx;
        y -= dy;
        z += arc_turns[i];
      end
    end
    cv = rnd_shift(x, TRIG_FRAC);
    sv = rnd_shift(y, TRIG_FRAC);
    if (cv > 32767) cv = 32767;
    if (cv < -32767) cv = -32767;
    if (sv > 32767) sv = 32767;
    if (sv < -32767) sv = -32767;
    if (flip) begin
      cv = -cv;
      sv = -sv;
    end
  endfunction

  function automatic int active_taps();
    if (cfg_taps == 0) return 1;
    if (int'(cfg_taps) > TAPS) return TAPS;
    return int'(cfg_taps);
  endfunction

  task automatic clear_delay_line();
    int d;
    for (d = 0; d < TAPS - 1; d++) begin
      hist_re[d] = 0;
      hist_im[d] = 0;
    end
    phase_acc = '0;
  endtask

  task automatic model_reset();
    int d;
    cfg_step = '0;
    cfg_taps = TAP_COUNT_RST;
    for (d = 0; d < TAPS; d++) coef_mem[d] = 0;
    clear_delay_line();
  endtask

  // mix down, filter, mix up; queue the expected output
  task automatic band_filter_sample(input sample_t in_re, input sample_t in_im);
    longint    xr, xm, cv, sv, mr, mm, acc_r, acc_m, yr, ym, or_v, om_v;
    bit        scratch, clipped;
    int        n, d;
    filt_res_t res;
    scratch   = 1'b0;
    clipped   = 1'b0;
    xr        = longint'(in_re);
    xm        = longint'(in_im);
    phase_acc = phase_acc + cfg_step;
    phase_trig(phase_acc, cv, sv);
    mr = clip_q15(rnd_shift(xr * cv + xm * sv, TRIG_FRAC), scratch);
    mm = clip_q15(rnd_shift(xm * cv - xr * sv, TRIG_FRAC), scratch);
    n     = active_taps();
    acc_r = coef_mem[n-1] * mr;
    acc_m = coef_mem[n-1] * mm;
    for (d = 1; d < n; d++) begin
      acc_r += coef_mem[n-1-d] * hist_re[d-1];
      acc_m += coef_mem[n-1-d] * hist_im[d-1];
    end
    // delay line always moves by one, whatever the tap count
    for (d = TAPS - 2; d > 0; d--) begin
      hist_re[d] = hist_re[d-1];
      hist_im[d] = hist_im[d-1];
    end
    hist_re[0] = mr;
    hist_im[0] = mm;
    yr   = rnd_shift(acc_r, COEF_W - 1);
    ym   = rnd_shift(acc_m, COEF_W - 1);
    or_v = clip_q15(rnd_shift(yr * cv - ym * sv, TRIG_FRAC), clipped);
    om_v = clip_q15(rnd_shift(yr * sv + ym * cv, TRIG_FRAC), clipped);
    res.re  = sample_t'(or_v);
    res.im  = sample_t'(om_v);
    res.sat = clipped;
    if (clipped) n_clipped++;
    filtered_q.push_back(res);
  endtask

  task automatic apply_item(input item_t it);
    case (it.kind)
      KIND_SAMPLE: begin
        band_filter_sample(it.re, it.im);
        n_samples++;
        n_items++;
      end
      KIND_LOAD: begin
        if (int'(it.tap) < TAPS) coef_mem[it.tap] = longint'(it.coef);
        n_loads++;
        n_items++;
      end
      KIND_CLEAR: begin
        clear_delay_line();
        n_clears++;
        n_items++;
      end
      default: n_ignored++;
    endcase
  endtask

  // ------------------------------------------------------------------------
  // item builders
  // ------------------------------------------------------------------------

  function automatic item_t noise_item(input logic [KIND_W-1:0] k);
    item_t it;
    it.kind = k;
    it.re   = sample_t'($urandom);
    it.im   = sample_t'($urandom);
    it.tap  = tap_idx_t'($urandom);
    it.coef = coef_t'($urandom);
    return it;
  endfunction

  function automatic item_t sample_item(input sample_t re, input sample_t im);
    item_t it;
    it    = noise_item(KIND_SAMPLE);
    it.re = re;
    it.im = im;
    return it;
  endfunction

  function automatic item_t load_item(input tap_idx_t tap, input coef_t val);
    item_t it;
    it      = noise_item(KIND_LOAD);
    it.tap  = tap;
    it.coef = val;
    return it;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return sample_t'(int'($urandom_range(0, 200)) - 100);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef(input int scale);
    coef_t v;
    v = coef_t'($urandom);
    return v >>> scale;
  endfunction

  // ------------------------------------------------------------------------
  // channel drivers
  // ------------------------------------------------------------------------

  // one input transfer; returns at the falling edge after it with valid high
  task automatic send_item(input item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= it.kind;
    in_if.sample_i   <= it.re;
    in_if.sample_q   <= it.im;
    in_if.tap_index  <= it.tap;
    in_if.coef_value <= it.coef;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    apply_item(it);
    @(negedge clk);
  endtask

  task automatic in_stop();
    in_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_results();
    while (filtered_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_PHASE_STEP: cfg_step = val[PHASE_W-1:0];
      CFG_TAP_COUNT:  cfg_taps = val[TAP_CNT_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // drain, let the last load or clear finish, then write both registers
  task automatic configure(input phase_t step, input tcount_t taps);
    in_stop();
    wait_results();
    repeat (SETTLE) @(negedge clk);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_PHASE_STEP, CFG_DATA_W'(step));
      write_reg(CFG_TAP_COUNT, CFG_DATA_W'(taps));
    end else begin
      write_reg(CFG_TAP_COUNT, CFG_DATA_W'(taps));
      write_reg(CFG_PHASE_STEP, CFG_DATA_W'(step));
    end
  endtask

  task automatic load_taps(input int scale);
    int k;
    for (k = 0; k < active_taps(); k++) send_item(load_item(tap_idx_t'(k), rand_coef(scale)));
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset settings, field extremes, every kind
  task automatic test_directed();
    send_item(sample_item(SAMPLE_MAX, SAMPLE_MAX));
    send_item(noise_item(KIND_UNUSED));
    send_item(load_item(tap_idx_t'(127), COEF_MAX));
    send_item(load_item(tap_idx_t'(126), COEF_MIN));
    send_item(load_item(tap_idx_t'(0), coef_t'(65536)));
    send_item(sample_item(SAMPLE_MAX, SAMPLE_MIN));
    send_item(sample_item(SAMPLE_MIN, SAMPLE_MIN));
    send_item(sample_item(sample_t'(0), sample_t'(0)));
    send_item(noise_item(KIND_CLEAR));
    send_item(sample_item(SAMPLE_MIN, SAMPLE_MAX));
    send_item(load_item(tap_idx_t'(64), coef_t'(-1)));
    send_item(sample_item(sample_t'(-1), sample_t'(1)));
  endtask

  // tap counts at and beyond the ends of the range, phase steps mostly on the fold boundaries
  task automatic test_tap_limits();
    int k;
    configure(phase_t'(24'h400000), tcount_t'(0));
    for (k = 0; k < 3; k++) send_item(sample_item(SAMPLE_MAX, rand_sample()));
    configure(phase_t'(24'hFFFFFF), tcount_t'(255));
    for (k = 0; k < 3; k++) send_item(sample_item(rand_sample(), SAMPLE_MIN));
    configure(phase_t'(24'h800000), tcount_t'(1));
    for (k = 0; k < 3; k++) send_item(sample_item(rand_sample(), rand_sample()));
    configure(phase_t'(24'hC00000), tcount_t'(128));
    for (k = 0; k < 3; k++) send_item(sample_item(SAMPLE_MIN, SAMPLE_MAX));
  endtask

  // one phase: new settings, mostly a coefficient set, then a mixed stream
  task automatic random_phase(input bit hold_off);
    phase_t  step;
    tcount_t taps;
    int      scale, len, pause_at, pick, k;
    case ($urandom_range(0, 5))
      0:       step = '0;
      1:       step = '1;
      2:       step = phase_t'($urandom_range(1, 4096));
      default: step = phase_t'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       taps = tcount_t'(1);
      1:       taps = tcount_t'(TAPS);
      2:       taps = tcount_t'($urandom_range(1, 16));
      3:       taps = tcount_t'($urandom_range(0, 255));
      default: taps = tcount_t'($urandom_range(1, TAPS));
    endcase
    configure(step, taps);
    idle_on = ($urandom_range(0, 3) != 0);
    scale   = $urandom_range(0, 9);
    if ($urandom_range(0, 4) != 0) load_taps(scale);
    len = $urandom_range(40, 90);
    if (hold_off) pause_at = len / 2;
    else if ($urandom_range(0, 2) == 0) pause_at = $urandom_range(0, len - 1);
    else pause_at = -1;
    for (k = 0; k < len; k++) begin
      // sender holds off until every filtered sample is back
      if (k == pause_at) begin
        in_stop();
        wait_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 84) send_item(sample_item(rand_sample(), rand_sample()));
      else if (pick < 92) send_item(load_item(tap_idx_t'($urandom), rand_coef(scale)));
      else if (pick < 96) send_item(noise_item(KIND_CLEAR));
      else send_item(noise_item(KIND_UNUSED));
    end
  endtask

  task automatic test_random_phases();
    bit first;
    first = 1'b1;
    while (n_items < ITEM_TARGET) begin
      random_phase(first);
      first = 1'b0;
    end
  endtask

  // back-to-back transfers with no idling on either side
  task automatic test_steady_stream();
    int k;
    configure(phase_t'($urandom), tcount_t'($urandom_range(1, 32)));
    idle_on = 1'b0;
    load_taps($urandom_range(2, 6));
    for (k = 0; k < 50; k++) send_item(sample_item(rand_sample(), rand_sample()));
    in_stop();
    wait_results();
  endtask

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------

  // random stall bursts on the result channel
  initial begin : result_sink
    int hold;
    hold         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        hold = $urandom_range(1, 15) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest prediction
  initial begin : result_check
    filt_res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result re=%0d im=%0d sat=%0b", $time,
                   out_if.out_i, out_if.out_q, out_if.saturated);
          n_errors++;
        end else begin
          want = filtered_q.pop_front();
          n_checked++;
          if (out_if.out_i !== want.re || out_if.out_q !== want.im ||
              out_if.saturated !== want.sat) begin
            $display("%0t: mismatch expected re=%0d im=%0d sat=%0b actual re=%0d im=%0d sat=%0b",
                     $time, want.re, want.im, want.sat,
                     out_if.out_i, out_if.out_q, out_if.saturated);
            n_errors++;
          end
        end
      end
    end
  end

  // ends the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
             WATCHDOG_LIMIT, filtered_q.size());
    $display("simulation failed");
    $finish;
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    arc_turns = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                  10430, 5215, 2608, 1304, 652, 326, 163, 81};
    n_items   = 0;
    n_samples = 0;
    n_loads   = 0;
    n_clears  = 0;
    n_ignored = 0;
    n_cfg     = 0;
    n_checked = 0;
    n_clipped = 0;
    n_errors  = 0;
    idle_on   = 1'b1;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_SAMPLE;
    in_if.sample_i   = '0;
    in_if.sample_q   = '0;
    in_if.tap_index  = '0;
    in_if.coef_value = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_PHASE_STEP;
    cfg_if.data      = '0;
    model_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_tap_limits();
    test_random_phases();
    test_steady_stream();

    repeat (SETTLE) @(negedge clk);
    $display("run covered %0d samples, %0d coefficient loads, %0d clears, %0d ignored items",
             n_samples, n_loads, n_clears, n_ignored);
    $display("%0d register writes, %0d results checked, %0d of them clipped, %0d errors",
             n_cfg, n_checked, n_clipped, n_errors);
    if (n_errors == 0 && filtered_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/csfb_pkg.sv
hdl/csfb_if.sv
hdl/csfb_cell.sv
hdl/csfb_cordic.sv
hdl/complex_shift_fir_bandpass.sv
tb/tb.sv
